[rtl/core/cumulative_table_sampler_defines.svh]
// Assertion macros for the cumulative table sampler.
// Each macro expects clk and rst_n in scope.
`ifndef CUMULATIVE_TABLE_SAMPLER_DEFINES_SVH
`define CUMULATIVE_TABLE_SAMPLER_DEFINES_SVH

// Same-cycle implication.
`define CTS_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTS_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cts_pkg.sv]
package cts_pkg;

    localparam int CTS_TABLE_DEPTH = 1024;

    localparam int LENGTH_W   = 11;
    localparam int WEIGHT_W   = 32;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 32;
    localparam int DRAW_W     = 31;
    localparam int BUCKET_W   = 10;
    localparam int PROD_W     = DRAW_W + WEIGHT_W;

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register select is the word address, paddr[2]
    localparam logic REG_TABLE_LENGTH = 1'b0;
    localparam logic REG_TOTAL_WEIGHT = 1'b1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Control bits that travel with every pipeline slot
    typedef struct packed {
        logic valid;
        logic is_load;
        logic searching;
    } cts_tag_t;

endpackage

[rtl/core/cts_scale.sv]
module cts_scale
    import cts_pkg::*;
#(
    parameter int TABLE_DEPTH = CTS_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic                req_type,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [VALUE_W-1:0]  entry_value,
    input  logic [DRAW_W-1:0]   draw,
    input  logic [WEIGHT_W-1:0] total_weight,
    input  logic [IDX_W-1:0]    last_index,
    output cts_tag_t            out_tag,
    output logic [VALUE_W-1:0]  out_word,
    output logic [IDX_W-1:0]    out_left,
    output logic [IDX_W-1:0]    out_right,
    output logic [IDX_W-1:0]    out_mid
);

    cts_tag_t            a_tag_reg, a_tag_next;
    logic [VALUE_W-1:0]  a_word_reg, a_word_next;
    logic [IDX_W-1:0]    a_idx_reg, a_idx_next;

    cts_tag_t            b_tag_reg, b_tag_next;
    logic [VALUE_W-1:0]  b_word_reg, b_word_next;
    logic [IDX_W-1:0]    b_left_reg, b_left_next;
    logic [IDX_W-1:0]    b_right_reg, b_right_next;
    logic [IDX_W-1:0]    b_mid_reg, b_mid_next;

    logic                in_range;
    logic [PROD_W-1:0]   prod;

    // Drop loads aimed past the table
    assign in_range = 32'(entry_index) < 32'(TABLE_DEPTH);

    always_comb
    begin
        a_tag_next.valid     = in_valid && (req_type == REQ_SAMPLE || in_range);
        a_tag_next.is_load   = (req_type == REQ_LOAD);
        a_tag_next.searching = 1'b0;
        a_word_next          = (req_type == REQ_LOAD) ? entry_value : VALUE_W'(draw);
        a_idx_next           = IDX_W'(entry_index);
    end

    assign prod = PROD_W'(a_word_reg[DRAW_W-1:0]) * PROD_W'(total_weight);

    always_comb
    begin
        b_tag_next.valid     = a_tag_reg.valid;
        b_tag_next.is_load   = a_tag_reg.is_load;
        // Only real samples search; bubbles pass through untouched
        b_tag_next.searching = a_tag_reg.valid && !a_tag_reg.is_load &&
                               (last_index > IDX_W'(1));
        b_word_next          = a_tag_reg.is_load ? a_word_reg : prod[PROD_W-1:DRAW_W];
        b_left_next          = a_tag_reg.is_load ? a_idx_reg : '0;
        b_right_next         = last_index;
        b_mid_next           = last_index >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
        end
        else if (en)
        begin
            a_tag_reg <= a_tag_next;
            b_tag_reg <= b_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_word_reg  <= a_word_next;
            a_idx_reg   <= a_idx_next;
            b_word_reg  <= b_word_next;
            b_left_reg  <= b_left_next;
            b_right_reg <= b_right_next;
            b_mid_reg   <= b_mid_next;
        end
    end

    assign out_tag   = b_tag_reg;
    assign out_word  = b_word_reg;
    assign out_left  = b_left_reg;
    assign out_right = b_right_reg;
    assign out_mid   = b_mid_reg;

endmodule

[rtl/core/cts_level.sv]
module cts_level
    import cts_pkg::*;
#(
    parameter int TABLE_DEPTH = CTS_TABLE_DEPTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  cts_tag_t           in_tag,
    input  logic [VALUE_W-1:0] in_word,
    input  logic [IDX_W-1:0]   in_left,
    input  logic [IDX_W-1:0]   in_right,
    input  logic [IDX_W-1:0]   in_mid,
    output cts_tag_t           out_tag,
    output logic [VALUE_W-1:0] out_word,
    output logic [IDX_W-1:0]   out_left,
    output logic [IDX_W-1:0]   out_right,
    output logic [IDX_W-1:0]   out_mid
);

    // Private copy of the table; loads write it as they pass this level
    logic [VALUE_W-1:0] entry_mem_reg [TABLE_DEPTH];

    cts_tag_t           r_tag_reg;
    logic [VALUE_W-1:0] r_word_reg;
    logic [IDX_W-1:0]   r_left_reg;
    logic [IDX_W-1:0]   r_right_reg;
    logic [IDX_W-1:0]   r_mid_reg;
    logic [VALUE_W-1:0] r_data_reg;

    cts_tag_t           u_tag_reg, u_tag_next;
    logic [VALUE_W-1:0] u_word_reg;
    logic [IDX_W-1:0]   u_left_reg, u_left_next;
    logic [IDX_W-1:0]   u_right_reg, u_right_next;
    logic [IDX_W-1:0]   u_mid_reg, u_mid_next;

    logic [IDX_W:0]     mid_sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_tag.valid && in_tag.is_load)
            begin
                entry_mem_reg[in_left] <= in_word;
            end
            r_data_reg <= entry_mem_reg[in_mid];
        end
    end

    always_comb
    begin
        u_tag_next   = r_tag_reg;
        u_left_next  = r_left_reg;
        u_right_next = r_right_reg;
        if (r_tag_reg.searching)
        begin
            if (r_data_reg == r_word_reg)
            begin
                // Exact hit: park the answer in left and stop
                u_left_next          = r_mid_reg;
                u_tag_next.searching = 1'b0;
            end
            else
            begin
                if (r_data_reg > r_word_reg)
                begin
                    u_right_next = r_mid_reg;
                end
                else
                begin
                    u_left_next = r_mid_reg;
                end
                u_tag_next.searching = (u_right_next - u_left_next) > IDX_W'(1);
            end
        end
        mid_sum    = (IDX_W + 1)'(u_left_next) + (IDX_W + 1)'(u_right_next);
        u_mid_next = mid_sum[IDX_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_tag_reg <= '0;
            u_tag_reg <= '0;
        end
        else if (en)
        begin
            r_tag_reg <= in_tag;
            u_tag_reg <= u_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_word_reg  <= in_word;
            r_left_reg  <= in_left;
            r_right_reg <= in_right;
            r_mid_reg   <= in_mid;
            u_word_reg  <= r_word_reg;
            u_left_reg  <= u_left_next;
            u_right_reg <= u_right_next;
            u_mid_reg   <= u_mid_next;
        end
    end

    assign out_tag   = u_tag_reg;
    assign out_word  = u_word_reg;
    assign out_left  = u_left_reg;
    assign out_right = u_right_reg;
    assign out_mid   = u_mid_reg;

endmodule

[rtl/core/cts_outbuf.sv]
module cts_outbuf
    import cts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [BUCKET_W-1:0] push_data,
    input  logic                pop,
    output logic                out_valid,
    output logic [BUCKET_W-1:0] out_data,
    output logic                full
);

    logic [BUCKET_W-1:0] slot_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign full      = (cnt_reg == 2'd2);

endmodule

[rtl/core/cumulative_table_sampler.sv]
// Cumulative table sampler: inverse-CDF sampling over a nondecreasing table of
// cumulative weights (unsigned Q0.32). A transfer with tuser = 0 loads one table
// entry; a transfer with tuser = 1 carries a 31-bit uniform draw, which is scaled
// to key = (draw * total_weight) >> 31 and searched for by binary search between
// index 0 and table_length - 1; the bucket index comes out on the master side.
// Loads give no output transfer. The block takes one transfer per cycle while the
// output buffer is not full or the master is ready: two stages capture and scale,
// then every search level is a read stage and an update stage with its own copy
// of the table, and results then pass through the two-entry output buffer.
// Loads travel down the same pipeline and write each level's copy as they pass,
// so samples see exactly the loads ahead of them. Read a table entry only after
// loading it. Write configuration only while no transfer is in flight.
`include "cumulative_table_sampler_defines.svh"

module cumulative_table_sampler
    import cts_pkg::*;
#(
    parameter int TABLE_DEPTH = CTS_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Slave side
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] entry_index, [41:10] entry_value, [72:42] draw, [79:73] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                  s_tuser,
    // Master side
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] bucket_index, [15:10] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LEVELS = IDX_W;

    // ---------------- configuration ----------------
    logic [LENGTH_W-1:0] table_length_reg;
    logic [WEIGHT_W-1:0] total_weight_reg;
    logic [IDX_W-1:0]    last_index_reg, last_index_next;
    logic                cfg_write;
    logic [LENGTH_W-1:0] wr_length;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign wr_length = pwdata[LENGTH_W-1:0];

    // Precompute the search's right bound: zero length acts as one,
    // lengths past the table saturate
    always_comb
    begin
        if (wr_length == '0)
        begin
            last_index_next = '0;
        end
        else if (32'(wr_length) >= 32'(TABLE_DEPTH))
        begin
            last_index_next = IDX_W'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_index_next = IDX_W'(wr_length - LENGTH_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= LENGTH_W'(1);
            total_weight_reg <= '0;
            last_index_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_TABLE_LENGTH:
                begin
                    table_length_reg <= wr_length;
                    last_index_reg   <= last_index_next;
                end
                REG_TOTAL_WEIGHT:
                begin
                    total_weight_reg <= pwdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_TABLE_LENGTH: prdata = APB_DATA_W'(table_length_reg);
            REG_TOTAL_WEIGHT: prdata = total_weight_reg;
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // One enable for every stage: advance whenever the output buffer has room or the master is ready
    logic                pipe_en;
    logic                buf_full;
    logic                buf_push;
    logic                buf_pop;
    logic [BUCKET_W-1:0] buf_data;

    cts_tag_t           lvl_tag   [LEVELS+1];
    logic [VALUE_W-1:0] lvl_word  [LEVELS+1];
    logic [IDX_W-1:0]   lvl_left  [LEVELS+1];
    logic [IDX_W-1:0]   lvl_right [LEVELS+1];
    logic [IDX_W-1:0]   lvl_mid   [LEVELS+1];

    assign pipe_en  = !buf_full || m_tready;
    assign s_tready = pipe_en;

    cts_scale #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (pipe_en),
        .in_valid     (s_tvalid),
        .req_type     (s_tuser),
        .entry_index  (s_tdata[INDEX_W-1:0]),
        .entry_value  (s_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
        .draw         (s_tdata[INDEX_W+VALUE_W+DRAW_W-1:INDEX_W+VALUE_W]),
        .total_weight (total_weight_reg),
        .last_index   (last_index_reg),
        .out_tag      (lvl_tag[0]),
        .out_word     (lvl_word[0]),
        .out_left     (lvl_left[0]),
        .out_right    (lvl_right[0]),
        .out_mid      (lvl_mid[0])
    );

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        cts_level #(
            .TABLE_DEPTH (TABLE_DEPTH)
        ) u_level (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_tag    (lvl_tag[g]),
            .in_word   (lvl_word[g]),
            .in_left   (lvl_left[g]),
            .in_right  (lvl_right[g]),
            .in_mid    (lvl_mid[g]),
            .out_tag   (lvl_tag[g+1]),
            .out_word  (lvl_word[g+1]),
            .out_left  (lvl_left[g+1]),
            .out_right (lvl_right[g+1]),
            .out_mid   (lvl_mid[g+1])
        );
    end

    // Samples leaving the last level go to the buffer; loads drop here
    assign buf_push = pipe_en && lvl_tag[LEVELS].valid && !lvl_tag[LEVELS].is_load;
    assign buf_pop  = m_tvalid && m_tready;

    cts_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (buf_push),
        .push_data (BUCKET_W'(lvl_left[LEVELS])),
        .pop       (buf_pop),
        .out_valid (m_tvalid),
        .out_data  (buf_data),
        .full      (buf_full)
    );

    assign m_tdata = M_TDATA_W'(buf_data);

    // ---------------- assertions ----------------
    `CTS_ASSERT_NOW(a_no_overflow, buf_push && !buf_pop, !buf_full,
        "result pushed into a full output buffer")
    `CTS_ASSERT_NOW(a_search_done,
        lvl_tag[LEVELS].valid && !lvl_tag[LEVELS].is_load,
        !lvl_tag[LEVELS].searching,
        "sample left the last level with its search still open")
    `CTS_ASSERT_NEXT(a_stall_holds, !pipe_en,
        lvl_tag[LEVELS] == $past(lvl_tag[LEVELS]) && lvl_left[LEVELS] == $past(lvl_left[LEVELS]),
        "pipeline end moved while stalled")

endmodule

[dv/tb.sv]
module tb;
    import cts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth is 2 + 2*clog2(depth) plus the output buffer; allow
    // well over that before touching configuration or ending the run.
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 22;
    localparam int HOLD_CYCLES  = 250;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // [9:0] entry_index, [41:10] entry_value, [72:42] draw, [79:73] zero
    logic [S_TDATA_W-1:0]  s_tdata;
    // [0] req_type
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // [9:0] bucket_index, [15:10] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    // Shadow of the block's state, updated at each accepted transfer.
    logic [LENGTH_W-1:0]   cfg_length;
    logic [WEIGHT_W-1:0]   cfg_total;
    logic [VALUE_W-1:0]    weight_table [CTS_TABLE_DEPTH];

    // Buckets predicted for accepted samples, oldest first.
    logic [BUCKET_W-1:0]   bucket_queue [$];

    int unsigned           error_count;
    int unsigned           cycle_count;
    // Set by a test to make the receiver hold off; the receiver clears it.
    int unsigned           hold_req;
    // Turns off idling on both sides for a stretch.
    bit                    steady;

    cumulative_table_sampler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and end the run if it hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    function automatic void note_error(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Scale the draw by the total weight, then binary search the table.
    function automatic logic [BUCKET_W-1:0] predict_bucket(input logic [DRAW_W-1:0] drw);
        logic [PROD_W-1:0]  prod;
        logic [VALUE_W-1:0] key;
        int unsigned        len;
        int unsigned        lo;
        int unsigned        hi;
        int unsigned        mid;
        prod = PROD_W'(drw) * PROD_W'(cfg_total);
        key  = prod[PROD_W-1:DRAW_W];
        len  = cfg_length;
        if (len < 1)
            len = 1;
        if (len > CTS_TABLE_DEPTH)
            len = CTS_TABLE_DEPTH;
        lo = 0;
        hi = len - 1;
        while (hi > lo + 1)
        begin
            mid = (lo + hi) / 2;
            if (weight_table[mid] == key)
                return BUCKET_W'(mid);
            if (weight_table[mid] > key)
                hi = mid;
            else
                lo = mid;
        end
        return BUCKET_W'(lo);
    endfunction

    // Pick a draw: the two extremes, one aimed at a table entry so that the
    // search can stop on an exact match, or a plain uniform one.
    function automatic logic [DRAW_W-1:0] pick_draw(input int eff);
        logic [63:0] d;
        int          j;
        int          r;
        r = $urandom_range(99);
        if (r < 15)
            return $urandom_range(1) ? 31'h7FFF_FFFF : 31'h0;
        if (r < 45 && cfg_total != 0)
        begin
            j = (eff >= 3) ? $urandom_range(eff - 2, 1) : 0;
            // Smallest draw whose key reaches the entry.
            d = ((64'(weight_table[j]) << DRAW_W) + 64'(cfg_total) - 1) / 64'(cfg_total);
            return (d > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : d[DRAW_W-1:0];
        end
        return DRAW_W'($urandom);
    endfunction

    // Offer one item and hold it until the transfer; predict on acceptance.
    task automatic send_item(input logic req, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val, input logic [DRAW_W-1:0] drw);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {7'b0, drw, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (req == REQ_LOAD)
            weight_table[idx] = val;
        else
            bucket_queue = {bucket_queue, predict_bucket(drw)};
    endtask

    // Drop the offer, wait for every bucket, then let loads drain out.
    task automatic settle_pipeline();
        s_tvalid <= 1'b0;
        while (bucket_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write both registers while idle and read them back.
    task automatic configure(input logic [LENGTH_W-1:0] len, input logic [WEIGHT_W-1:0] total);
        logic [APB_DATA_W-1:0] rd;
        settle_pipeline();
        apb_access(1'b1, {REG_TABLE_LENGTH, 2'b00}, APB_DATA_W'(len), rd);
        apb_access(1'b1, {REG_TOTAL_WEIGHT, 2'b00}, total, rd);
        cfg_length = len;
        cfg_total  = total;
        apb_access(1'b0, {REG_TABLE_LENGTH, 2'b00}, '0, rd);
        if (rd !== APB_DATA_W'(len))
            note_error("table_length readback", APB_DATA_W'(len), rd);
        apb_access(1'b0, {REG_TOTAL_WEIGHT, 2'b00}, '0, rd);
        if (rd !== total)
            note_error("total_weight readback", total, rd);
    endtask

    // Configure, optionally load a fresh nondecreasing prefix covering every
    // entry the search can reach, then draw samples with a few stray loads.
    task automatic run_phase(input logic [LENGTH_W-1:0] len, input logic [WEIGHT_W-1:0] total,
                             input int n_samples, input bit reload);
        int          eff;
        int          i;
        logic [63:0] level;
        logic [63:0] span;
        configure(len, total);
        eff = (len < 1) ? 1 : ((len > CTS_TABLE_DEPTH) ? CTS_TABLE_DEPTH : int'(len));
        if (reload)
        begin
            level = 0;
            span  = (64'(total) * 2) / eff + 1;
            for (i = 0; i < eff; i++)
            begin
                // Leave some steps flat so equal neighbors show up.
                if ($urandom_range(7) != 0)
                    level += {$urandom, $urandom} % span;
                if (level > 64'hFFFF_FFFF)
                    level = 64'hFFFF_FFFF;
                send_item(REQ_LOAD, INDEX_W'(i), level[31:0], DRAW_W'($urandom));
            end
        end
        for (i = 0; i < n_samples; i++)
        begin
            if ($urandom_range(99) < 10)
                send_item(REQ_LOAD, INDEX_W'($urandom), $urandom, DRAW_W'($urandom));
            send_item(REQ_SAMPLE, INDEX_W'($urandom), $urandom, pick_draw(eff));
        end
    endtask

    // Reset values: length one, zero weight; every draw lands in bucket 0.
    task automatic test_reset_values();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, {REG_TABLE_LENGTH, 2'b00}, '0, rd);
        if (rd !== 32'd1)
            note_error("table_length after reset", 32'd1, rd);
        apb_access(1'b0, {REG_TOTAL_WEIGHT, 2'b00}, '0, rd);
        if (rd !== 32'd0)
            note_error("total_weight after reset", 32'd0, rd);
        send_item(REQ_SAMPLE, '0, '0, 31'h0);
        send_item(REQ_SAMPLE, '1, '1, 31'h7FFF_FFFF);
    endtask

    // Zero length, length two, top and bottom indexes, extreme draws and an
    // exact hit on a table entry.
    task automatic test_directed();
        configure(11'd0, 32'hFFFF_FFFF);
        send_item(REQ_SAMPLE, '0, '0, 31'h7FFF_FFFF);

        configure(11'd4, 32'hFFFF_FFFF);
        send_item(REQ_LOAD, 10'd0, 32'h0000_0000, '0);
        send_item(REQ_LOAD, 10'd1, 32'h4000_0000, '1);
        send_item(REQ_LOAD, 10'd2, 32'hC000_0000, '0);
        send_item(REQ_LOAD, 10'd3, 32'hFFFF_FFFF, '1);
        send_item(REQ_LOAD, 10'd1023, 32'hFFFF_FFFF, '0);
        send_item(REQ_LOAD, 10'd1023, 32'h0000_0000, '1);
        send_item(REQ_SAMPLE, '0, '0, 31'h0);
        send_item(REQ_SAMPLE, '1, '1, 31'h7FFF_FFFF);
        send_item(REQ_SAMPLE, '0, '1, 31'h4000_0000);

        configure(11'd2, 32'h0100_0000);
        send_item(REQ_SAMPLE, '0, '0, 31'h5555_5555);

        // Weight of exactly one half: the key equals the draw.
        configure(11'd4, 32'h8000_0000);
        send_item(REQ_SAMPLE, '0, '0, 31'h4000_0000);
        send_item(REQ_SAMPLE, '0, '0, 31'h3FFF_FFFF);
    endtask

    // Mostly small tables with a spread of weights, zero and full scale too.
    task automatic test_small_tables();
        run_phase(11'd2, 32'h0000_0000, 40, 1'b1);
        run_phase(11'd3, 32'hFFFF_FFFF, 40, 1'b1);
        run_phase(11'd7, 32'h8000_0000, 40, 1'b1);
        run_phase(11'd16, 32'h0100_0000, 40, 1'b1);
        run_phase(11'd45, $urandom, 40, 1'b1);
        run_phase(LENGTH_W'($urandom_range(100, 5)), $urandom, 40, 1'b1);
    endtask

    // Fill the whole table once with no idling, then reuse it with a length
    // beyond the depth, which saturates.
    task automatic test_full_table();
        steady = 1'b1;
        run_phase(11'd1024, 32'hFFFF_FFFF, 100, 1'b1);
        steady = 1'b0;
        run_phase(11'd2047, $urandom, 60, 1'b0);
    endtask

    // Stall the receiver for a long stretch while samples keep coming, so the
    // pipeline fills and the input stalls.
    task automatic test_backpressure();
        int i;
        settle_pipeline();
        hold_req = HOLD_CYCLES;
        steady   = 1'b1;
        for (i = 0; i < 80; i++)
            send_item(REQ_SAMPLE, INDEX_W'($urandom), $urandom, pick_draw(CTS_TABLE_DEPTH));
        steady = 1'b0;
    endtask

    // Receiver: check each result transfer, then pick the next tready.
    initial
    begin : receiver
        logic [BUCKET_W-1:0] want;
        int unsigned         hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    if (bucket_queue.size() == 0)
                        note_error("unexpected bucket", '0, 32'(m_tdata));
                    else
                    begin
                        want = bucket_queue.pop_front();
                        if (m_tdata !== {6'b0, want})
                            note_error("bucket_index", 32'(want), 32'(m_tdata));
                    end
                end
                if (hold_req != 0)
                begin
                    hold_left = hold_req;
                    hold_req  = 0;
                end
                if (hold_left != 0)
                begin
                    hold_left--;
                    m_tready <= 1'b0;
                end
                else if (steady)
                    m_tready <= 1'b1;
                else
                    m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        error_count = 0;
        hold_req    = 0;
        steady      = 1'b0;
        cfg_length  = 11'd1;
        cfg_total   = '0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_LOAD;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed();
        test_small_tables();
        test_full_table();
        test_backpressure();

        settle_pipeline();
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/cts_pkg.sv
rtl/core/cts_scale.sv
rtl/core/cts_level.sv
rtl/core/cts_outbuf.sv
rtl/core/cumulative_table_sampler.sv
dv/tb.sv
